[rtl/prf_pkg.sv]
`timescale 1ns / 1ps

package prf_pkg;

	localparam int BYTE_W = 8;
	localparam int LEN_W = 6;

	localparam logic [LEN_W-1:0] MIN_LENGTH_RESET = 6'd4;
	localparam logic [BYTE_W-1:0] LINE_END = 8'h0A;
	localparam logic [BYTE_W-1:0] TAB_CHAR = 8'h09;
	localparam logic [BYTE_W-1:0] TEXT_LOW = 8'h20;
	localparam logic [BYTE_W-1:0] TEXT_HIGH = 8'h7E;

	typedef logic [BYTE_W-1:0] byte_t;

	function automatic logic is_text(input byte_t b);
		logic r;
		r = (b == TAB_CHAR) || ((b >= TEXT_LOW) && (b <= TEXT_HIGH));
		return r;
	endfunction

endpackage

[rtl/printable_run_filter_unit.sv]
`timescale 1ns / 1ps

// Printable run filter. Bytes enter on the s_axis group, one per beat, and
// the kept text leaves on the m_axis group, one character per beat, with
// tlast marking the final character caused by an input byte. The cfg channel
// writes min_length; it is always ready, and the user must write it only
// while the block is idle; the block itself does not enforce this.
// A byte that is stored into the run buffer or dropped produces no output
// beat. A byte that needs no buffer flush produces its one beat in the
// output register on the next cycle. A byte that finds a full buffer not
// yet emitted starts a flush: the buffer memory is read one entry per cycle
// while the receiver takes the beats, each entry goes out as one beat and
// then the final character, and no input byte is accepted until it is done.
// The output register decouples the sides: a new byte is taken while a
// result waits only when that waiting beat is taken in the same cycle.
// When the receiver stalls, the beat holds and the flush and the input both
// wait.
// After reset the run is empty, min_length is 4 and the output is empty. The
// buffer memory is not cleared; an entry is always written before it is read.
module printable_run_filter_unit #(
	parameter int MAX_MIN_LENGTH = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	input  prf_pkg::byte_t      s_axis_tdata,   // [7:0] in_byte
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	output prf_pkg::byte_t      m_axis_tdata,   // [7:0] out_byte
	output logic                m_axis_tlast,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [prf_pkg::LEN_W-1:0] cfg_data
);
	import prf_pkg::*;

	localparam int AW = (MAX_MIN_LENGTH > 1) ? $clog2(MAX_MIN_LENGTH) : 1;
	localparam int CW = $clog2(MAX_MIN_LENGTH + 1);
	localparam logic [CW-1:0] MAX_LEN = CW'(MAX_MIN_LENGTH);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_FLUSH = 1'b1;

	byte_t run_mem [MAX_MIN_LENGTH];

	logic [LEN_W-1:0] min_length_q;
	logic [CW-1:0] run_count_q;
	logic flush_pending_q;
	logic state_q;
	logic [CW-1:0] idx_q;
	byte_t tail_byte_q;
	byte_t rd_data_s1;
	logic rdv_s1;
	logic out_valid_q;
	byte_t out_byte_q;
	logic out_last_q;

	logic [CW-1:0] m_eff;
	logic out_free;
	logic in_beat;
	logic in_text;
	logic move;
	logic issue;
	logic tail;

	always_comb begin
		if (min_length_q > LEN_W'(MAX_MIN_LENGTH)) begin
			m_eff = MAX_LEN;
		end else begin
			m_eff = CW'(min_length_q);
		end
	end

	assign out_free = !out_valid_q || m_axis_tready;
	assign s_axis_tready = (state_q == ST_IDLE) && out_free;
	assign in_beat = s_axis_tvalid && s_axis_tready;
	assign in_text = is_text(s_axis_tdata);
	assign move = (state_q == ST_FLUSH) && rdv_s1 && out_free;
	assign issue = (state_q == ST_FLUSH) && (idx_q < m_eff) && (!rdv_s1 || move);
	assign tail = (state_q == ST_FLUSH) && (idx_q >= m_eff) && !rdv_s1 && out_free;
	assign cfg_ready = 1'b1;

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = out_byte_q;
	assign m_axis_tlast = out_last_q;

	always_ff @(posedge clk) begin
		if (in_beat && (run_count_q < m_eff) && in_text) begin
			run_mem[run_count_q[AW-1:0]] <= s_axis_tdata;
		end
		if (issue) begin
			rd_data_s1 <= run_mem[idx_q[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_length_q <= MIN_LENGTH_RESET;
		end else if (cfg_valid && cfg_ready) begin
			min_length_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_count_q <= '0;
			flush_pending_q <= 1'b1;
			state_q <= ST_IDLE;
			idx_q <= '0;
			rdv_s1 <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_beat) begin
						if (run_count_q < m_eff) begin
							if (in_text) begin
								run_count_q <= run_count_q + 1'b1;
								flush_pending_q <= 1'b1;
							end else begin
								run_count_q <= '0;
								flush_pending_q <= 1'b0;
							end
						end else begin
							flush_pending_q <= 1'b0;
							if (!in_text) begin
								run_count_q <= '0;
							end
							if (flush_pending_q && (m_eff != '0)) begin
								state_q <= ST_FLUSH;
								idx_q <= '0;
							end
						end
					end
				end
				ST_FLUSH: begin
					if (issue) begin
						idx_q <= idx_q + 1'b1;
						rdv_s1 <= 1'b1;
					end else if (move) begin
						rdv_s1 <= 1'b0;
					end
					if (tail) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_beat && (state_q == ST_IDLE)) begin
			tail_byte_q <= in_text ? s_axis_tdata : LINE_END;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((in_beat && (run_count_q >= m_eff)
				&& !(flush_pending_q && (m_eff != '0))) || move || tail) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			out_byte_q <= rd_data_s1;
			out_last_q <= 1'b0;
		end else if (tail) begin
			out_byte_q <= tail_byte_q;
			out_last_q <= 1'b1;
		end else if (in_beat && (run_count_q >= m_eff)) begin
			out_byte_q <= in_text ? s_axis_tdata : LINE_END;
			out_last_q <= 1'b1;
		end
	end

	a_rdv_only_in_flush: assert property (@(posedge clk) disable iff (!arst_n)
		rdv_s1 |-> (state_q == ST_FLUSH))
		else $error("read data valid outside a flush");

	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FLUSH) |-> (idx_q <= m_eff))
		else $error("flush index ran past the buffer length");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		run_count_q <= MAX_LEN)
		else $error("run count above buffer depth");

	a_tail_returns_idle: assert property (@(posedge clk) disable iff (!arst_n)
		tail |=> (state_q == ST_IDLE) && out_valid_q && out_last_q)
		else $error("flush did not end with a final beat");

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps

module tb;
	import prf_pkg::*;

	localparam int MAX_MIN_LENGTH = 32;
	localparam int BUF_AW = $clog2(MAX_MIN_LENGTH);
	localparam int CYCLE_LIMIT = 1000000;
	localparam int SETTLE_CYCLES = MAX_MIN_LENGTH + 8;
	localparam int HOLD_CYCLES = 300;

	typedef struct packed {
		byte_t data;
		logic  last;
	} char_beat_t;

	logic clk;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	byte_t s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	byte_t m_axis_tdata;
	logic m_axis_tlast;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [LEN_W-1:0] cfg_data = '0;

	byte_t held_chars [MAX_MIN_LENGTH];
	logic [LEN_W-1:0] held_count = '0;
	logic dump_pending = 1'b1;
	logic [LEN_W-1:0] min_run = MIN_LENGTH_RESET;
	char_beat_t pending_chars [$];
	char_beat_t seen_beat;
	char_beat_t wanted_beat;

	int errors = 0;
	int cycle_count = 0;
	int sender_idle_pct = 0;
	int receiver_idle_pct = 0;
	int hold_request = 0;
	int hold_left = 0;

	printable_run_filter_unit #(
		.MAX_MIN_LENGTH(MAX_MIN_LENGTH)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tlast(m_axis_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: run did not finish in time", $time);
			$display("Some tests failed");
			$finish;
		end
	end

	// The receiver idles at random, or holds off for a counted stretch on request.
	always @(posedge clk) begin
		if (hold_left == 0 && hold_request != 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left != 0) begin
			m_axis_tready <= 1'b0;
			hold_left--;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= receiver_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready) begin
			seen_beat = '{data: m_axis_tdata, last: m_axis_tlast};
			if (pending_chars.size() == 0) begin
				errors++;
				$display("%0t: unexpected beat, expected none, actual data %h last %b",
					$time, seen_beat.data, seen_beat.last);
			end else begin
				wanted_beat = pending_chars.pop_front();
				if (seen_beat.data !== wanted_beat.data) begin
					errors++;
					$display("%0t: out_byte mismatch, expected %h, actual %h",
						$time, wanted_beat.data, seen_beat.data);
				end
				if (seen_beat.last !== wanted_beat.last) begin
					errors++;
					$display("%0t: last_of_run mismatch, expected %b, actual %b",
						$time, wanted_beat.last, seen_beat.last);
				end
			end
		end
	end

	function automatic logic printable(input byte_t b);
		return (b == 8'h09) || (b >= 8'h20 && b <= 8'h7E);
	endfunction

	function automatic logic [LEN_W-1:0] run_threshold();
		return (min_run > MAX_MIN_LENGTH) ? LEN_W'(MAX_MIN_LENGTH) : min_run;
	endfunction

	// Works out the characters that one accepted byte releases.
	function automatic void filter_byte(input byte_t b);
		logic [LEN_W-1:0] limit;
		logic [LEN_W-1:0] k;
		limit = run_threshold();
		if (held_count < limit) begin
			if (printable(b)) begin
				held_chars[held_count[BUF_AW-1:0]] = b;
				held_count++;
				dump_pending = 1'b1;
			end else begin
				held_count = '0;
				dump_pending = 1'b0;
			end
		end else begin
			if (dump_pending) begin
				for (k = '0; k < limit; k++)
					pending_chars.push_back('{data: held_chars[k[BUF_AW-1:0]], last: 1'b0});
				dump_pending = 1'b0;
			end
			if (printable(b)) begin
				pending_chars.push_back('{data: b, last: 1'b1});
			end else begin
				pending_chars.push_back('{data: LINE_END, last: 1'b1});
				held_count = '0;
			end
		end
	endfunction

	function automatic byte_t random_text();
		if ($urandom_range(15) == 0)
			return TAB_CHAR;
		return byte_t'($urandom_range(8'h20, 8'h7E));
	endfunction

	function automatic byte_t random_nontext();
		case ($urandom_range(2))
			0: return byte_t'($urandom_range(8'h00, 8'h08));
			1: return byte_t'($urandom_range(8'h0A, 8'h1F));
			default: return byte_t'($urandom_range(8'h7F, 8'hFF));
		endcase
	endfunction

	task automatic send_byte(input byte_t b);
		while ($urandom_range(99) < sender_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		do
			@(posedge clk);
		while (!s_axis_tready);
		filter_byte(b);
	endtask

	task automatic send_string(input string s);
		int k;
		for (k = 0; k < s.len(); k++)
			send_byte(byte_t'(s[k]));
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (pending_chars.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_min_length(input logic [LEN_W-1:0] value);
		wait_drained();
		repeat (4) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		min_run = value;
	endtask

	task automatic test_default_runs();
		send_string("abc");
		send_byte(8'h00);
		send_byte(8'h20);
		send_byte(8'h7E);
		send_byte(TAB_CHAR);
		send_byte(8'h41);
		send_byte(8'hFF);
		send_string("ABCDE");
		send_byte(8'h1F);
		wait_drained();
	endtask

	task automatic test_zero_length();
		set_min_length(6'd0);
		send_byte(8'h7F);
		send_byte(8'h80);
		send_byte(8'h41);
		send_byte(LINE_END);
		wait_drained();
	endtask

	task automatic test_length_change_mid_run();
		set_min_length(6'd4);
		send_string("ab");
		set_min_length(6'd2);
		send_byte(8'h63);
		send_byte(8'h00);
		wait_drained();
	endtask

	task automatic test_backpressure();
		int k;
		set_min_length(6'd4);
		hold_request = HOLD_CYCLES;
		for (k = 0; k < 60; k++)
			send_byte(random_text());
		send_byte(random_nontext());
		wait_drained();
	endtask

	task automatic random_segment(input logic [LEN_W-1:0] len, input int budget);
		int sent;
		int run_len;
		int k;
		set_min_length(len);
		sent = 0;
		while (sent < budget) begin
			if ($urandom_range(4) == 0) begin
				send_byte(byte_t'($urandom_range(255)));
				sent++;
			end else begin
				run_len = $urandom_range(0, run_threshold() + 8);
				for (k = 0; k < run_len; k++)
					send_byte(random_text());
				send_byte(random_nontext());
				sent += run_len + 1;
			end
		end
	endtask

	task automatic test_random_traffic(input int send_pct, input int recv_pct);
		sender_idle_pct = send_pct;
		receiver_idle_pct = recv_pct;
		random_segment(6'd4, 8);
		random_segment(6'd0, 8);
		random_segment(6'd32, 25);
		random_segment(6'd1, 8);
		random_segment(6'd63, 25);
		random_segment(LEN_W'($urandom_range(2, 16)), 8);
		wait_drained();
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_default_runs();
		test_zero_length();
		test_length_change_mid_run();
		test_backpressure();
		test_random_traffic(21, 83);
		test_random_traffic(83, 21);
		test_random_traffic(0, 0);
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (pending_chars.size() != 0) begin
			errors++;
			$display("%0t: %0d expected beats never arrived", $time, pending_chars.size());
		end
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

[sim.f]
rtl/prf_pkg.sv
rtl/printable_run_filter_unit.sv
verif/tb.sv
